### rtl/smfd_pkg.sv
// shared types and constants for the multiplexer frame deframer
`default_nettype none

package smfd_pkg;

    localparam int MAX_VARINT_BYTES = 10;
    localparam int CNT_W            = 4;
    localparam int WORD_W           = 64;
    localparam int FLAG_W           = 3;
    localparam int SN_W             = WORD_W - FLAG_W;
    localparam int BYTE_W           = 8;
    localparam int KIND_W           = 2;
    localparam int SHIFT_W          = 7;

    localparam logic [FLAG_W-1:0] FLAG_RESERVED = 3'd7;

    // tdata layout of a result word, from the lowest bit up
    localparam int TDATA_USED = SN_W + FLAG_W + 1 + WORD_W + BYTE_W;
    localparam int TDATA_W    = ((TDATA_USED + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SN_W-1:0]    stream_id;
        logic [FLAG_W-1:0]  flag;
        logic               flag_invalid;
        logic [WORD_W-1:0]  length;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

### rtl/smfd_parser.sv
// frame parse state: varint decoding, header, payload and error result generation
`default_nettype none

module smfd_parser
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_take,
    input  wire logic [smfd_pkg::BYTE_W-1:0] in_byte,
    output logic                            res_valid,
    output smfd_pkg::res_t                  res
);
    import smfd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] remain_reg, remain_next;

    logic [SHIFT_W-1:0] shift;
    logic [WORD_W-1:0]  acc_fed;
    logic [CNT_W-1:0]   cnt_inc;
    logic               vi_done;
    logic               vi_err;
    logic [WORD_W-1:0]  remain_dec;
    logic               remain_zero;
    logic               len_zero;

    // shift stays below 64 since the count never passes nine here
    assign shift      = SHIFT_W'(cnt_reg) * SHIFT_W'(7);
    assign acc_fed    = acc_reg | ({{(WORD_W-7){1'b0}}, in_byte[6:0]} << shift);
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign vi_done    = ~in_byte[7];
    assign vi_err     = in_byte[7] && (cnt_inc >= CNT_W'(MAX_VARINT_BYTES));
    assign remain_dec = remain_reg - WORD_W'(1);
    assign remain_zero = (remain_dec == '0);
    assign len_zero   = (acc_fed == '0);

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        remain_next = remain_reg;
        if (in_take)
        begin
            if (phase_reg == PH_DATA)
            begin
                remain_next = remain_dec;
                if (remain_zero)
                begin
                    phase_next = PH_ID;
                    word_next  = '0;
                end
            end
            else if (vi_err)
            begin
                phase_next  = PH_ID;
                acc_next    = '0;
                cnt_next    = '0;
                word_next   = '0;
                remain_next = '0;
            end
            else if (!vi_done)
            begin
                acc_next = acc_fed;
                cnt_next = cnt_inc;
            end
            else if (phase_reg == PH_LEN)
            begin
                acc_next = '0;
                cnt_next = '0;
                if (len_zero)
                begin
                    phase_next = PH_ID;
                    word_next  = '0;
                end
                else
                begin
                    phase_next  = PH_DATA;
                    remain_next = acc_fed;
                end
            end
            else
            begin
                // id varint complete, also for the unused phase code
                word_next  = acc_fed;
                acc_next   = '0;
                cnt_next   = '0;
                phase_next = PH_LEN;
            end
        end
    end

    // result word
    always_comb
    begin
        res               = '0;
        res.kind          = KIND_HEADER;
        res_valid         = 1'b0;
        res.stream_id     = word_reg[WORD_W-1:FLAG_W];
        res.flag          = word_reg[FLAG_W-1:0];
        res.flag_invalid  = (word_reg[FLAG_W-1:0] == FLAG_RESERVED);
        if (phase_reg == PH_DATA)
        begin
            res_valid        = in_take;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = in_byte;
            res.last         = remain_zero;
        end
        else if (vi_err)
        begin
            res_valid = in_take;
            res       = '0;
            res.kind  = KIND_ERROR;
            res.last  = 1'b1;
        end
        else if (vi_done && phase_reg == PH_LEN)
        begin
            res_valid  = in_take;
            res.length = acc_fed;
            res.last   = len_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            word_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            word_reg   <= word_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

### rtl/smfd_out_buf.sv
// output register with a skid stage that parks one word while the output is held
`default_nettype none

module smfd_out_buf
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire smfd_pkg::res_t push_res,
    output logic                push_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output smfd_pkg::res_t      out_res
);
    import smfd_pkg::*;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;
    logic load_out;

    assign load_out   = !out_valid_reg || out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_res_next   = push_res;
            end
        end
        else if (push)
        begin
            // output held by the receiver: park the word
            skid_valid_next = 1'b1;
            skid_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

`default_nettype wire

### rtl/stream_mux_frame_deframer.sv
// top level of the multiplexer frame deframer
//
// usage: the slave stream carries one byte of a framed stream per word in
// s_tdata. each frame is a varint id (stream number and 3-bit flag), a
// varint length, then that many payload bytes. the master stream gives
// one word per header (tuser 0), per payload byte (tuser 1) or per varint
// longer than ten bytes (tuser 2, parse restarts). tlast marks the final
// word of a frame, and is set on every error word.
// varint bytes that do not complete a header give no output word.
// throughput: one input byte per cycle, sustained while m_tready is high.
// output: the parser forms each result word combinationally from the accepted
// byte, and the output register (or the skid stage, while held) captures it.
// stall: a two-entry output (register plus skid stage) parks one more word
// while a word waits; s_tready drops while the skid is full.
// reset: asynchronous, clears the parse state to expect an id varint and
// empties the output stage.
`default_nettype none

module stream_mux_frame_deframer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [smfd_pkg::BYTE_W-1:0]   s_tdata,   // data_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // stream id, flag, flag_invalid, length, payload_byte, zero pad
    output logic [smfd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [smfd_pkg::KIND_W-1:0]        m_tuser,   // kind
    output logic                               m_tlast    // last
);
    import smfd_pkg::*;

    logic in_take;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign in_take = s_tvalid && s_tready;

    smfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    smfd_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_res   (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {{(TDATA_W-TDATA_USED){1'b0}},
                      out_res.payload_byte,
                      out_res.length,
                      out_res.flag_invalid,
                      out_res.flag,
                      out_res.stream_id};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

### test/stream_mux_frame_deframer_tb.sv
// self-checking testbench for the multiplexer frame deframer
module stream_mux_frame_deframer_tb;
    import smfd_pkg::*;

    localparam int ITEMS_PER_PASS = 150;
    localparam int STALL_LIMIT    = 5000;

    // tracks the parse of the accepted byte stream and holds the words it must produce
    class deframer_checker;
        phase_t       parse_phase;
        logic [63:0]  acc;
        logic [3:0]   acc_bytes;
        logic [63:0]  id_word;
        logic [63:0]  remaining;
        res_t         expected_words[$];
        int           errors;

        function new();
            parse_phase = PH_ID;
            acc         = '0;
            acc_bytes   = '0;
            id_word     = '0;
            remaining   = '0;
            errors      = 0;
        endfunction

        function automatic res_t frame_fields(kind_t k, logic [63:0] w);
            res_t r;
            r               = '0;
            r.kind          = k;
            r.stream_id     = w[WORD_W-1:FLAG_W];
            r.flag          = w[FLAG_W-1:0];
            r.flag_invalid  = (w[FLAG_W-1:0] == FLAG_RESERVED);
            return r;
        endfunction

        function automatic void take_byte(logic [7:0] b);
            res_t r;
            if (parse_phase == PH_DATA)
            begin
                remaining         = remaining - 64'd1;
                r                 = frame_fields(KIND_PAYLOAD, id_word);
                r.payload_byte    = b;
                r.last            = (remaining == 0);
                if (r.last)
                begin
                    parse_phase = PH_ID;
                    id_word     = '0;
                end
                expected_words.push_back(r);
                return;
            end
            if (7 * acc_bytes < 64)
                acc = acc | (64'(b[6:0]) << (7 * acc_bytes));
            acc_bytes = acc_bytes + 4'd1;
            if (b[7])
            begin
                // continuation bit still set on the tenth byte: error word, parse starts over
                if (acc_bytes >= MAX_VARINT_BYTES)
                begin
                    parse_phase = PH_ID;
                    acc         = '0;
                    acc_bytes   = '0;
                    id_word     = '0;
                    remaining   = '0;
                    r           = '0;
                    r.kind      = KIND_ERROR;
                    r.last      = 1'b1;
                    expected_words.push_back(r);
                end
                return;
            end
            if (parse_phase == PH_LEN)
            begin
                r        = frame_fields(KIND_HEADER, id_word);
                r.length = acc;
                r.last   = (acc == 0);
                if (acc == 0)
                begin
                    parse_phase = PH_ID;
                    id_word     = '0;
                end
                else
                begin
                    parse_phase = PH_DATA;
                    remaining   = acc;
                end
                acc       = '0;
                acc_bytes = '0;
                expected_words.push_back(r);
            end
            else
            begin
                id_word     = acc;
                acc         = '0;
                acc_bytes   = '0;
                parse_phase = PH_LEN;
            end
        endfunction

        function automatic string describe(res_t r);
            return $sformatf("kind=%0d sn=%h flag=%0d inv=%0d len=%h byte=%h last=%0d",
                             r.kind, r.stream_id, r.flag, r.flag_invalid,
                             r.length, r.payload_byte, r.last);
        endfunction

        function automatic void check_word(logic [KIND_W-1:0] user,
                                           logic [TDATA_W-1:0] data, logic last);
            res_t got;
            res_t want;
            got               = '0;
            got.kind          = kind_t'(user);
            got.stream_id     = data[SN_W-1:0];
            got.flag          = data[SN_W +: FLAG_W];
            got.flag_invalid  = data[SN_W+FLAG_W];
            got.length        = data[SN_W+FLAG_W+1 +: WORD_W];
            got.payload_byte  = data[SN_W+FLAG_W+1+WORD_W +: BYTE_W];
            got.last          = last;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %s",
                         $time, describe(got));
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: mismatch, expected %s, actual %s",
                         $time, describe(want), describe(got));
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;

    deframer_checker     sb;
    int                  send_idle;
    int                  recv_idle;
    int                  bytes_sent;
    int                  stall_cycles;

    stream_mux_frame_deframer u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tuser, m_tdata, m_tlast);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[stream_mux_frame_deframer] ERROR");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    function automatic int varint_len(logic [63:0] v);
        int n;
        n = 1;
        while (n < MAX_VARINT_BYTES && (v >> (7 * n)) != 0)
            n++;
        return n;
    endfunction

    // nbytes above the minimum gives a padded, still legal encoding
    task automatic send_varint(input logic [63:0] v, input int nbytes);
        logic [63:0] t;
        int          i;
        for (i = 0; i < nbytes; i++)
        begin
            t = v >> (7 * i);
            send_byte({(i < nbytes - 1), t[6:0]});
        end
    endtask

    task automatic send_frame(input logic [63:0] id, input int id_bytes,
                              input logic [63:0] len, input int len_bytes, input int npay);
        send_varint(id, id_bytes);
        send_varint(len, len_bytes);
        repeat (npay)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_overlong();
        repeat (MAX_VARINT_BYTES)
            send_byte(8'h80 | 8'($urandom_range(0, 127)));
    endtask

    // finish whatever a noise byte left half done, keeping lengths small
    task automatic resync();
        while (!(sb.parse_phase == PH_ID && sb.acc_bytes == 0))
        begin
            if (sb.parse_phase == PH_DATA)
                send_byte(8'($urandom_range(0, 255)));
            else if (sb.parse_phase == PH_LEN && sb.acc_bytes == 0)
                send_byte(8'($urandom_range(0, 6)));
            else
                send_byte(8'h00);
        end
    endtask

    function automatic int pick_bytes(logic [63:0] v);
        int n;
        n = varint_len(v);
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(n, MAX_VARINT_BYTES);
        return n;
    endfunction

    task automatic random_frame();
        logic [63:0] id;
        logic [63:0] len;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            if ($urandom_range(0, 3) == 0)
                id = {$urandom, $urandom} >> $urandom_range(0, 63);
            else
                id = 64'($urandom_range(0, 40)) << FLAG_W;
            id[FLAG_W-1:0] = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 85)
                len = 64'($urandom_range(0, 6));
            else
                len = 64'($urandom_range(7, 24));
            send_frame(id, pick_bytes(id), len, pick_bytes(len), int'(len));
        end
        else if (pick < 90)
        begin
            send_byte(8'($urandom_range(0, 255)));
            resync();
        end
        else
        begin
            // over-long varint in the id or in the length
            if ($urandom_range(0, 1) == 1)
            begin
                id = 64'($urandom_range(0, 127));
                send_varint(id, 1);
            end
            send_overlong();
        end
    endtask

    initial
    begin
        int pass_no;
        sb           = new();
        bytes_sent   = 0;
        stall_cycles = 0;
        send_idle    = 35;
        recv_idle    = 55;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // empty frame, stream 0 flag 0: header is also the last word
        send_frame(64'h0, 1, 64'h0, 1, 0);
        send_frame({61'd5, 3'd1}, 1, 64'd3, 1, 0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        // reserved flag code still framed
        send_frame({61'd2, FLAG_RESERVED}, 1, 64'd1, 1, 0);
        send_byte(8'h7F);
        // widest stream number, empty payload
        send_frame({64{1'b1}}, MAX_VARINT_BYTES, 64'h0, 1, 0);
        send_overlong();

        for (pass_no = 0; pass_no < 3; pass_no++)
        begin
            if (pass_no == 1)
            begin
                send_idle = 55;
                recv_idle = 35;
            end
            else if (pass_no == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            while (bytes_sent < 31 + ITEMS_PER_PASS * (pass_no + 1))
                random_frame();
        end

        // largest length, bits beyond 63 dropped; left open so it comes last
        send_varint({61'd1, 3'd2}, 1);
        send_byte(8'hFF);
        repeat (MAX_VARINT_BYTES - 2)
            send_byte(8'hFF);
        send_byte(8'h7F);
        repeat (3)
            send_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("[stream_mux_frame_deframer] OK");
        else
            $display("[stream_mux_frame_deframer] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/smfd_pkg.sv
rtl/smfd_parser.sv
rtl/smfd_out_buf.sv
rtl/stream_mux_frame_deframer.sv
test/stream_mux_frame_deframer_tb.sv
